/* rtl/core/path_normalizer_defines.svh */
// Assertion macros used by the path normalizer datapath.
`ifndef PATH_NORMALIZER_DEFINES_SVH
`define PATH_NORMALIZER_DEFINES_SVH

// Check an expression at every rising clock edge outside reset.
`define PN_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define PN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/pn_pkg.sv */
// Types and constants shared by the path normalizer modules.
package pn_pkg;

  localparam logic [7:0] SLASH_CHAR  = 8'h2F;
  localparam logic [7:0] DOT_CHAR    = 8'h2E;
  localparam logic [3:0] CHUNK_BYTES = 4'd8;

  typedef struct packed {
    logic [7:0] path_char;
    logic       end_of_path;
  } pn_in_t;

  typedef struct packed {
    logic [63:0] text_bytes;
    logic [3:0]  byte_count;
    logic        last_chunk;
  } pn_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_END,
    ST_LEN_RD,
    ST_LEN_WAIT,
    ST_BYTE_RD,
    ST_BYTE_PUT,
    ST_SLASH,
    ST_LAST
  } pn_state_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic take_char;
    logic end_close;
    logic len_rd;
    logic len_latch;
    logic byte_rd;
    logic append_byte;
    logic append_slash;
    logic next_seg;
    logic emit_last;
    logic clear_path;
  } pn_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic out_free;
    logic append_ok;
    logic seg_done;
    logic more_segs;
    logic last_byte;
    logic pos_full;
  } pn_status_t;

endpackage

/* rtl/core/pn_stream_if.sv */
// Valid/ready stream channel carrying one payload per transaction.
interface pn_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/path_normalizer.sv */
// Path normalizer: input is ready every cycle while idle, where character items are taken.
// An end item closes the open segment, then for each segment looks up its length and
// appends its characters (store read, then pack) and a joining slash, both stores having
// registered reads; then it emits the final chunk. Output stalls hold the walk, and it
// stops early at the output capacity. Chunks leave through an output register.
// Reset (async, active low) clears the path state; the segment store needs no clearing.
module path_normalizer #(
  parameter int unsigned MAX_SEGMENTS    = 16,
  parameter int unsigned SEGMENT_BYTES   = 32,
  parameter int unsigned OUTPUT_CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pn_stream_if.sink   in_item_i,
  pn_stream_if.source out_item_o
);
  import pn_pkg::*;

  pn_cmd_t    cmd;
  pn_status_t status;
  logic       in_ready;
  logic       out_valid;
  pn_out_t    out_payload;
  logic       in_has_char;

  // A zero character carries no character; the item may still end the path
  assign in_has_char = in_item_i.payload.path_char != 8'd0;

  // Sequencer: accepts transactions in idle, walks the stack on the end item
  pn_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_item_i.valid),
    .in_has_char_i (in_has_char),
    .in_end_i      (in_item_i.payload.end_of_path),
    .in_ready_o    (in_ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Datapath: segment stack, store, packing and output register
  pn_datapath #(
    .MAX_SEGMENTS    (MAX_SEGMENTS),
    .SEGMENT_BYTES   (SEGMENT_BYTES),
    .OUTPUT_CAPACITY (OUTPUT_CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .path_char_i (in_item_i.payload.path_char),
    .out_ready_i (out_item_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_payload)
  );

  assign in_item_i.ready    = in_ready;
  assign out_item_o.valid   = out_valid;
  assign out_item_o.payload = out_payload;
endmodule

/* rtl/core/pn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/core/pn_ctrl.sv */
// Sequencer: takes input transactions and walks the segment stack on the end item.
module pn_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_has_char_i,
  input  logic                in_end_i,
  output logic                in_ready_o,
  input  pn_pkg::pn_status_t  status_i,
  output pn_pkg::pn_cmd_t     cmd_o
);
  import pn_pkg::*;

  pn_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_char = in_has_char_i;
          if (in_end_i) begin
            state_d = ST_END;
          end
        end
      end
      ST_END: begin
        cmd_o.end_close = 1'b1;
        state_d         = ST_LEN_RD;
      end
      ST_LEN_RD: begin
        if (status_i.seg_done) begin
          state_d = ST_LAST;
        end else begin
          cmd_o.len_rd = 1'b1;
          state_d      = ST_LEN_WAIT;
        end
      end
      ST_LEN_WAIT: begin
        cmd_o.len_latch = 1'b1;
        state_d         = ST_BYTE_RD;
      end
      ST_BYTE_RD: begin
        cmd_o.byte_rd = 1'b1;
        state_d       = ST_BYTE_PUT;
      end
      ST_BYTE_PUT: begin
        if (status_i.pos_full) begin
          state_d = ST_LAST;
        end else if (status_i.append_ok) begin
          cmd_o.append_byte = 1'b1;
          if (!status_i.last_byte) begin
            state_d = ST_BYTE_RD;
          end else if (status_i.more_segs) begin
            state_d = ST_SLASH;
          end else begin
            state_d = ST_LAST;
          end
        end
      end
      ST_SLASH: begin
        if (status_i.pos_full) begin
          state_d = ST_LAST;
        end else if (status_i.append_ok) begin
          cmd_o.append_slash = 1'b1;
          cmd_o.next_seg     = 1'b1;
          state_d            = ST_LEN_RD;
        end
      end
      ST_LAST: begin
        if (status_i.out_free) begin
          cmd_o.emit_last  = 1'b1;
          cmd_o.clear_path = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end
endmodule

/* rtl/core/pn_datapath.sv */
// Datapath: segment stack, segment store, output packing and result register.
`include "path_normalizer_defines.svh"

module pn_datapath #(
  parameter int unsigned MAX_SEGMENTS    = 16,
  parameter int unsigned SEGMENT_BYTES   = 32,
  parameter int unsigned OUTPUT_CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pn_pkg::pn_cmd_t    cmd_i,
  output pn_pkg::pn_status_t status_o,
  input  logic [7:0]         path_char_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output pn_pkg::pn_out_t    out_item_o
);
  import pn_pkg::*;

  localparam int unsigned SegMaxLen  = SEGMENT_BYTES - 1;
  localparam int unsigned LenW       = $clog2(SEGMENT_BYTES);
  localparam int unsigned StoreDepth = MAX_SEGMENTS * SegMaxLen;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);
  localparam int unsigned BaseW      = $clog2(StoreDepth + 1);
  localparam int unsigned CountW     = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SegAw      = $clog2(MAX_SEGMENTS);
  localparam int unsigned PosW       = $clog2(OUTPUT_CAPACITY);

  // Path state
  logic [LenW-1:0]   cur_len_q, cur_len_d;
  logic [CountW-1:0] seg_count_q, seg_count_d;
  logic              at_start_q, at_start_d;
  logic              full_q, full_d;
  logic [BaseW-1:0]  push_base_q, push_base_d;
  logic [7:0]        first_q, first_d;
  logic [7:0]        second_q, second_d;

  // Walk state
  logic [CountW-1:0] seg_idx_q, seg_idx_d;
  logic [BaseW-1:0]  walk_base_q, walk_base_d;
  logic [LenW-1:0]   byte_idx_q, byte_idx_d;
  logic [LenW-1:0]   seg_len_q, seg_len_d;
  logic [63:0]       pack_q, pack_d;
  logic [3:0]        pack_cnt_q, pack_cnt_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              out_valid_q, out_valid_d;
  pn_out_t           out_q, out_d;

  logic              close_en;
  logic [LenW-1:0]   close_len;
  logic [LenW-1:0]   cur_next;
  logic              store_we;
  logic [StoreAw-1:0] store_waddr, store_raddr;
  logic [7:0]        store_rdata;
  logic              len_we;
  logic [SegAw-1:0]  len_waddr;
  logic [LenW-1:0]   len_rdata;
  logic              out_free;
  logic [7:0]        byte_in;

  assign cur_next    = cur_len_q + LenW'(1);
  assign store_waddr = StoreAw'(push_base_q + BaseW'(cur_len_q));
  assign store_raddr = StoreAw'(walk_base_q + BaseW'(byte_idx_q));
  assign len_waddr   = seg_count_q[SegAw-1:0];
  assign out_free    = !out_valid_q || out_ready_i;
  assign byte_in     = cmd_i.append_slash ? SLASH_CHAR : store_rdata;

  always_comb begin
    cur_len_d   = cur_len_q;
    seg_count_d = seg_count_q;
    at_start_d  = at_start_q;
    full_d      = full_q;
    push_base_d = push_base_q;
    first_d     = first_q;
    second_d    = second_q;
    seg_idx_d   = seg_idx_q;
    walk_base_d = walk_base_q;
    byte_idx_d  = byte_idx_q;
    seg_len_d   = seg_len_q;
    pack_d      = pack_q;
    pack_cnt_d  = pack_cnt_q;
    pos_d       = pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    close_en    = 1'b0;
    close_len   = cur_len_q;
    store_we    = 1'b0;
    len_we      = 1'b0;

    // Take one character into the open segment
    if (cmd_i.take_char && !full_q) begin
      at_start_d = 1'b0;
      if (at_start_q && path_char_i == SLASH_CHAR) begin
        at_start_d = 1'b0;
      end else if (path_char_i == SLASH_CHAR) begin
        close_en = 1'b1;
      end else begin
        store_we  = 1'b1;
        cur_len_d = cur_next;
        if (cur_len_q == '0) begin
          first_d = path_char_i;
        end
        if (cur_len_q == LenW'(1)) begin
          second_d = path_char_i;
        end
        if (cur_next == LenW'(SegMaxLen)) begin
          close_en  = 1'b1;
          close_len = cur_next;
        end
      end
    end

    // Close the open segment on the end item and seed the text with the root slash
    if (cmd_i.end_close) begin
      close_en    = !full_q;
      pack_d      = {56'd0, SLASH_CHAR};
      pack_cnt_d  = 4'd1;
      pos_d       = PosW'(1);
      seg_idx_d   = '0;
      walk_base_d = '0;
    end

    // Drop, pop or push the closed segment
    if (close_en) begin
      cur_len_d = '0;
      if (close_len != '0) begin
        if (close_len == LenW'(2) && first_q == DOT_CHAR && second_q == DOT_CHAR) begin
          if (seg_count_q != '0) begin
            seg_count_d = seg_count_q - CountW'(1);
            push_base_d = push_base_q - BaseW'(SegMaxLen);
          end
        end else if (!(close_len == LenW'(1) && first_q == DOT_CHAR)) begin
          len_we      = 1'b1;
          seg_count_d = seg_count_q + CountW'(1);
          push_base_d = push_base_q + BaseW'(SegMaxLen);
          if (seg_count_q + CountW'(1) == CountW'(MAX_SEGMENTS)) begin
            full_d = 1'b1;
          end
        end
      end
    end

    if (cmd_i.len_latch) begin
      seg_len_d  = len_rdata;
      byte_idx_d = '0;
    end

    // Append one character; hand off a full chunk first
    if (cmd_i.append_byte || cmd_i.append_slash) begin
      pos_d = pos_q + PosW'(1);
      if (pack_cnt_q == CHUNK_BYTES) begin
        out_d.text_bytes = pack_q;
        out_d.byte_count = pack_cnt_q;
        out_d.last_chunk = 1'b0;
        out_valid_d      = 1'b1;
        pack_d           = {56'd0, byte_in};
        pack_cnt_d       = 4'd1;
      end else begin
        for (int k = 0; k < 8; k++) begin
          if (pack_cnt_q[2:0] == 3'(k)) begin
            pack_d[8*k +: 8] = byte_in;
          end
        end
        pack_cnt_d = pack_cnt_q + 4'd1;
      end
    end

    if (cmd_i.append_byte) begin
      byte_idx_d = byte_idx_q + LenW'(1);
    end

    if (cmd_i.next_seg) begin
      seg_idx_d   = seg_idx_q + CountW'(1);
      walk_base_d = walk_base_q + BaseW'(SegMaxLen);
    end

    if (cmd_i.emit_last) begin
      out_d.text_bytes = pack_q;
      out_d.byte_count = pack_cnt_q;
      out_d.last_chunk = 1'b1;
      out_valid_d      = 1'b1;
      pack_cnt_d       = '0;
    end

    if (cmd_i.clear_path) begin
      cur_len_d   = '0;
      seg_count_d = '0;
      at_start_d  = 1'b1;
      full_d      = 1'b0;
      push_base_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_len_q   <= '0;
      seg_count_q <= '0;
      at_start_q  <= 1'b1;
      full_q      <= 1'b0;
      push_base_q <= '0;
      seg_idx_q   <= '0;
      walk_base_q <= '0;
      byte_idx_q  <= '0;
      pack_cnt_q  <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_len_q   <= cur_len_d;
      seg_count_q <= seg_count_d;
      at_start_q  <= at_start_d;
      full_q      <= full_d;
      push_base_q <= push_base_d;
      seg_idx_q   <= seg_idx_d;
      walk_base_q <= walk_base_d;
      byte_idx_q  <= byte_idx_d;
      pack_cnt_q  <= pack_cnt_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q   <= first_d;
    second_q  <= second_d;
    seg_len_q <= seg_len_d;
    pack_q    <= pack_d;
    out_q     <= out_d;
  end

  pn_ram #(
    .WIDTH (8),
    .DEPTH (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (path_char_i),
    .re_i    (cmd_i.byte_rd),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  pn_ram #(
    .WIDTH (LenW),
    .DEPTH (MAX_SEGMENTS)
  ) u_lengths (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (close_len),
    .re_i    (cmd_i.len_rd),
    .raddr_i (seg_idx_q[SegAw-1:0]),
    .rdata_o (len_rdata)
  );

  assign status_o.out_free  = out_free;
  assign status_o.append_ok = (pack_cnt_q != CHUNK_BYTES) || out_free;
  assign status_o.seg_done  = seg_idx_q >= seg_count_q;
  assign status_o.more_segs = (seg_idx_q + CountW'(1)) < seg_count_q;
  assign status_o.last_byte = (byte_idx_q + LenW'(1)) == seg_len_q;
  assign status_o.pos_full  = pos_q == PosW'(OUTPUT_CAPACITY - 1);

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PN_ASSERT_ALWAYS(a_full_tracks_count, full_q == (seg_count_q == CountW'(MAX_SEGMENTS)), "stack full flag out of step with segment count")
  `PN_ASSERT_ALWAYS(a_open_len_bound, cur_len_q < LenW'(SegMaxLen), "open segment reached its limit without closing")
  `PN_ASSERT_NEXT(a_start_cleared, cmd_i.take_char, !at_start_q, "path start flag still set after a character")
  `PN_ASSERT_ALWAYS(a_last_not_empty, !cmd_i.emit_last || pack_cnt_q != '0, "final chunk issued with no characters")
endmodule

/* dv/path_normalizer_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for path_normalizer: streams paths in, checks normalized chunks out.
module path_normalizer_test;
  import pn_pkg::*;

  localparam int unsigned MAX_SEGS     = 16;
  localparam int unsigned SEG_BYTES    = 32;
  localparam int unsigned OUT_CAP      = 256;
  localparam int unsigned SEG_LIMIT    = SEG_BYTES - 1;
  localparam int unsigned RANDOM_ITEMS = 400;
  // Turn idling off once this few items are left to send.
  localparam int unsigned CALM_ITEMS   = 40;
  localparam int unsigned MAX_GAP      = 19;
  // Allow far more than a chunk's walk plus the longest output stall.
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum int {SEG_NAME, SEG_DOT, SEG_DOTDOT, SEG_EMPTY, SEG_LONG} seg_kind_e;
  typedef enum int {PATH_PLAIN, PATH_FULL, PATH_WIDE, PATH_NOISE} path_kind_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pn_stream_if #(.payload_t(pn_in_t))  in_ch ();
  pn_stream_if #(.payload_t(pn_out_t)) out_ch ();

  path_normalizer #(
    .MAX_SEGMENTS   (MAX_SEGS),
    .SEGMENT_BYTES  (SEG_BYTES),
    .OUTPUT_CAPACITY(OUT_CAP)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_ch),
    .out_item_o(out_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Segment stack predictor: mirrors the block's path state item by item.
  // ---------------------------------------------------------------------------
  logic [7:0]  seg_text [MAX_SEGS][SEG_LIMIT];
  int unsigned seg_len [MAX_SEGS];
  int unsigned depth      = 0;     // segments on the stack
  int unsigned open_len   = 0;     // characters in the segment being built
  bit          path_fresh = 1'b1;  // next character is the first of the path
  bit          stack_held = 1'b0;  // stack full, characters ignored until the end
  pn_out_t     expected_chunks[$];

  // Close the open segment: drop empty and ".", pop on "..", push anything else.
  function automatic void close_open_segment();
    int unsigned n;
    n = open_len;
    open_len = 0;
    if (n == 0 || depth >= MAX_SEGS) return;
    if (n == 2 && seg_text[depth][0] == DOT_CHAR && seg_text[depth][1] == DOT_CHAR) begin
      if (depth > 0) depth--;
      return;
    end
    if (n == 1 && seg_text[depth][0] == DOT_CHAR) return;
    seg_len[depth] = n;
    depth++;
    if (depth >= MAX_SEGS) stack_held = 1'b1;
  endfunction

  function automatic void take_path_char(logic [7:0] c);
    if (stack_held) return;
    // Skip one leading slash only.
    if (path_fresh) begin
      path_fresh = 1'b0;
      if (c == SLASH_CHAR) return;
    end
    if (c == SLASH_CHAR) begin
      close_open_segment();
      return;
    end
    seg_text[depth][open_len] = c;
    open_len++;
    // A segment at its size limit closes by itself.
    if (open_len >= SEG_LIMIT) close_open_segment();
  endfunction

  // Build "/" plus the joined segments, cut to OUT_CAP-1 characters, 8 per chunk.
  function automatic void emit_normalized_path();
    logic [7:0]  text[$];
    pn_out_t     chunk;
    int unsigned cnt;
    text.push_back(SLASH_CHAR);
    for (int unsigned i = 0; i < depth; i++) begin
      for (int unsigned j = 0; j < seg_len[i]; j++)
        if (text.size() < OUT_CAP - 1) text.push_back(seg_text[i][j]);
      if (i + 1 < depth && text.size() < OUT_CAP - 1) text.push_back(SLASH_CHAR);
    end
    for (int unsigned i = 0; i < text.size(); i += 8) begin
      chunk = '0;
      cnt = (text.size() - i > 8) ? 8 : text.size() - i;
      for (int unsigned j = 0; j < cnt; j++) chunk.text_bytes[8*j +: 8] = text[i + j];
      chunk.byte_count = cnt[3:0];
      chunk.last_chunk = (i + cnt >= text.size());
      expected_chunks.push_back(chunk);
    end
  endfunction

  // Character first, then the end: close, emit, and start a fresh path.
  function automatic void advance_path(pn_in_t item);
    if (item.path_char != 8'h00) take_path_char(item.path_char);
    if (!item.end_of_path) return;
    if (!stack_held) close_open_segment();
    emit_normalized_path();
    depth      = 0;
    open_len   = 0;
    path_fresh = 1'b1;
    stack_held = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: a queue of pending items, filled up front by the initial block.
  // ---------------------------------------------------------------------------
  pn_in_t      pending_items[$];
  int unsigned counted_items = 0;

  function automatic void push_item(logic [7:0] c, logic fin);
    pn_in_t item;
    item.path_char   = c;
    item.end_of_path = fin;
    pending_items.push_back(item);
    // Items with neither character nor end do nothing; leave them out of the count.
    if (c != 8'h00 || fin) counted_items++;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endfunction

  // Mostly letters, some dots, the rest any nonzero byte (slashes included).
  function automatic logic [7:0] name_char();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 8'h61 + 8'($urandom_range(0, 25));
    if (pick == 6) return DOT_CHAR;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void push_segment(seg_kind_e kind);
    int unsigned n;
    n = 0;
    case (kind)
      SEG_NAME:   n = $urandom_range(1, 6);
      SEG_LONG:   n = $urandom_range(SEG_LIMIT - 2, SEG_LIMIT + 4);
      SEG_DOT:    push_item(DOT_CHAR, 1'b0);
      SEG_DOTDOT: push_text("..");
      default:    n = 0;
    endcase
    for (int unsigned i = 0; i < n; i++) begin
      // Sprinkle empty items between characters now and then.
      if ($urandom_range(0, 19) == 0) push_item(8'h00, 1'b0);
      push_item(name_char(), 1'b0);
    end
  endfunction

  // End the path on an item of its own or together with the last character.
  function automatic void end_path();
    int unsigned last;
    if (pending_items.size() != 0 && $urandom_range(0, 1) == 1) begin
      last = pending_items.size() - 1;
      if (pending_items[last].path_char != 8'h00 && !pending_items[last].end_of_path) begin
        pending_items[last].end_of_path = 1'b1;
        return;
      end
    end
    push_item(8'h00, 1'b1);
  endfunction

  function automatic void push_path(path_kind_e kind);
    int unsigned segs;
    case (kind)
      PATH_FULL:  segs = $urandom_range(MAX_SEGS + 2, MAX_SEGS + 5);
      PATH_WIDE:  segs = $urandom_range(9, 10);
      PATH_NOISE: segs = $urandom_range(1, 12);
      default:    segs = $urandom_range(0, 6);
    endcase
    // Noise: raw bytes with a rare end; a path may be left open for the next one.
    if (kind == PATH_NOISE) begin
      repeat (segs) push_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    if ($urandom_range(0, 9) < 7) push_item(SLASH_CHAR, 1'b0);
    for (int unsigned i = 0; i < segs; i++) begin
      if (i != 0) push_item(SLASH_CHAR, 1'b0);
      case (kind)
        // One early pop, and a final ".." that must be ignored once the stack is full.
        PATH_FULL:  push_segment((i == 2 || i == segs - 1) ? SEG_DOTDOT : SEG_NAME);
        PATH_WIDE:  push_segment(SEG_LONG);
        default:    push_segment(seg_kind_e'($urandom_range(SEG_NAME, SEG_LONG)));
      endcase
    end
    if ($urandom_range(0, 3) == 0) push_item(SLASH_CHAR, 1'b0);
    end_path();
  endfunction

  // ---------------------------------------------------------------------------
  // Driver and output back-pressure: change inputs at the falling edge.
  // ---------------------------------------------------------------------------
  int unsigned in_gap    = 0;
  int unsigned out_stall = 0;
  bit          in_taken  = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && !in_taken) begin
        // Hold the transaction until the block takes it.
      end else if (in_gap != 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, MAX_GAP - 1);
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_ch.payload <= pending_items.pop_front();
        in_ch.valid   <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end

      if (out_stall != 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 9) == 0) begin
        out_stall = $urandom_range(0, MAX_GAP - 1);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input transaction, check each output transaction.
  // ---------------------------------------------------------------------------
  int unsigned mismatches   = 0;
  int unsigned chunk_index  = 0;
  int unsigned quiet_cycles = 0;

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endfunction

  always @(posedge clk_i) begin : monitor_blk
    pn_out_t want;
    in_taken <= in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) advance_path(in_ch.payload);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chunks.size() == 0) begin
          note_error($sformatf("chunk %0d not expected: text %h count %0d last %0b",
                               chunk_index, out_ch.payload.text_bytes,
                               out_ch.payload.byte_count, out_ch.payload.last_chunk));
        end else begin
          want = expected_chunks.pop_front();
          if (out_ch.payload.text_bytes != want.text_bytes)
            note_error($sformatf("chunk %0d text_bytes: expected %h, got %h", chunk_index,
                                 want.text_bytes, out_ch.payload.text_bytes));
          if (out_ch.payload.byte_count != want.byte_count)
            note_error($sformatf("chunk %0d byte_count: expected %0d, got %0d", chunk_index,
                                 want.byte_count, out_ch.payload.byte_count));
          if (out_ch.payload.last_chunk != want.last_chunk)
            note_error($sformatf("chunk %0d last_chunk: expected %0b, got %0b", chunk_index,
                                 want.last_chunk, out_ch.payload.last_chunk));
        end
        chunk_index++;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("** path_normalizer: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: fill the queue, reset, drain, report.
  // ---------------------------------------------------------------------------
  initial begin : sequence_blk
    int unsigned random_goal;
    int unsigned pick;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;

    // Directed: end on an empty path, an item that does nothing, ".." on an
    // empty stack (with the end riding on the last character), dot handling
    // with a double slash, and the extreme character codes.
    push_item(8'h00, 1'b1);
    push_item(8'h00, 1'b0);
    push_text("/../.");
    push_item(DOT_CHAR, 1'b1);
    push_text("a/./b//../c");
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'h01, 1'b1);

    // Random: start with one path aimed at a full stack and one at a truncated output, then mix.
    random_goal = counted_items + RANDOM_ITEMS;
    push_path(PATH_FULL);
    push_path(PATH_WIDE);
    while (counted_items < random_goal) begin
      pick = $urandom_range(0, 49);
      if (pick < 41)      push_path(PATH_PLAIN);
      else if (pick < 45) push_path(PATH_FULL);
      else if (pick < 46) push_path(PATH_WIDE);
      else                push_path(PATH_NOISE);
    end
    // Close whatever noise may have left open.
    push_item(8'h00, 1'b1);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_ch.valid) @(negedge clk_i);
    while (expected_chunks.size() != 0) @(negedge clk_i);
    // Let any stray chunk show up before judging.
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && expected_chunks.size() == 0) begin
      $display("** path_normalizer: PASSED **");
    end else begin
      $display("** path_normalizer: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/pn_pkg.sv
rtl/core/pn_stream_if.sv
rtl/core/pn_ram.sv
rtl/core/pn_ctrl.sv
rtl/core/pn_datapath.sv
rtl/core/path_normalizer.sv
dv/path_normalizer_test.sv
